// ===== hw/rtl/bbt_pkg.sv =====
// ----------------------------------------------------------------------------
// Backoff blacklist table package
// Shared widths, operation and status codes, and the expiry test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbt_pkg;

	localparam int ADDR_W    = 48;
	localparam int TIME_W    = 56;
	localparam int ENTRY_W   = ADDR_W + 2 * TIME_W;
	localparam int IN_DATA_W = ADDR_W + 3 * TIME_W;
	localparam int OUT_DATA_W = 72;
	localparam int CFG_IDX_W = 2;

	localparam int LIST_DEPTH_DEF       = 16;
	localparam int HISTORY_DEPTH_DEF    = 32;
	localparam int PENALTY_MULTIPLE_DEF = 2;

	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_LOOKUP = 2'd1,
		MODE_WASH   = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_HIST_FULL = 2'd1,
		STAT_LIST_FULL = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SURVIVAL_CAP   = 2'd0,
		CFG_PENALTY_PERIOD = 2'd1,
		CFG_HIST_OVERDUE   = 2'd2
	} cfg_idx_t;

	// An entry has run out when now is not before its stamp and the age
	// has reached the limit.
	function automatic logic run_out(input logic [TIME_W-1:0] now,
		input logic [TIME_W-1:0] stamp, input logic [TIME_W-1:0] limit);
		logic [TIME_W:0] age;
		age = {1'b0, now} - {1'b0, stamp};
		return !age[TIME_W] && (age[TIME_W-1:0] >= limit);
	endfunction

endpackage

// ===== hw/rtl/backoff_blacklist_table_top.sv =====
// ----------------------------------------------------------------------------
// Backoff blacklist table
// Blacklist and history tables of server addresses with exponential backoff.
// ----------------------------------------------------------------------------
// Each beat runs alone: after acceptance the sequencer reads the history and
// the blacklist one entry per cycle through one compare unit; an add then also
// multiplies, selects the grant and writes the tables. The result sits in an
// output register, so the next beat is taken while it waits.
`timescale 1ns / 1ps

module backoff_blacklist_table_top #(
	parameter int LIST_DEPTH       = bbt_pkg::LIST_DEPTH_DEF,
	parameter int HISTORY_DEPTH    = bbt_pkg::HISTORY_DEPTH_DEF,
	parameter int PENALTY_MULTIPLE = bbt_pkg::PENALTY_MULTIPLE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bbt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bbt_pkg::TIME_W-1:0]     cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// server_address[47:0], service_time[103:48], requested_survival[159:104],
	// time_now[215:160]
	input  logic [bbt_pkg::IN_DATA_W-1:0]  s_tdata,
	// mode[1:0]
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// granted_survival[55:0], is_listed[56], listed_count[61:57],
	// removed_count[67:62], status[69:68], zero pad[71:70]
	output logic [bbt_pkg::OUT_DATA_W-1:0] m_tdata
);

	localparam int LIW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int HIW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

	logic                        h_we, h_re, l_we, l_re;
	logic [HIW-1:0]              h_waddr, h_raddr;
	logic [LIW-1:0]              l_waddr, l_raddr;
	logic [bbt_pkg::ENTRY_W-1:0] h_wdata, h_rdata, l_wdata, l_rdata;

	// Sequencer and compare unit.
	bbt_seq #(
		.LIST_DEPTH      (LIST_DEPTH),
		.HISTORY_DEPTH   (HISTORY_DEPTH),
		.PENALTY_MULTIPLE(PENALTY_MULTIPLE)
	) u_seq (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata,
		.h_we, .h_waddr, .h_wdata, .h_re, .h_raddr, .h_rdata,
		.l_we, .l_waddr, .l_wdata, .l_re, .l_raddr, .l_rdata
	);

	// History table: address, survival and stamp.
	bbt_ram #(.DEPTH(HISTORY_DEPTH), .WIDTH(bbt_pkg::ENTRY_W)) u_hist (
		.clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.re(h_re), .raddr(h_raddr), .rdata(h_rdata)
	);

	// Blacklist table: address, survival and stamp.
	bbt_ram #(.DEPTH(LIST_DEPTH), .WIDTH(bbt_pkg::ENTRY_W)) u_list (
		.clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.re(l_re), .raddr(l_raddr), .rdata(l_rdata)
	);

	// An accepted beat keeps the block busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("block ready right after accepting a beat");

	// A failed add never reports a granted survival.
	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[69:68] != bbt_pkg::STAT_OK)) |-> (m_tdata[55:0] == '0))
		else $error("granted survival on a failed add");

	// A lookup hit comes with no removals and no error.
	a_lookup_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[56]) |-> ((m_tdata[67:62] == '0) &&
		(m_tdata[69:68] == bbt_pkg::STAT_OK) && (m_tdata[55:0] == '0)))
		else $error("lookup result mixed with other results");

endmodule

// ===== hw/rtl/bbt_ram.sv =====
// ----------------------------------------------------------------------------
// Table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbt_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 160,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/bbt_seq.sv =====
// ----------------------------------------------------------------------------
// Backoff blacklist sequencer
// Scans both tables one entry a cycle through a shared compare unit, then,
// for an add, works out the granted survival and writes the tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbt_seq #(
	parameter int LIST_DEPTH       = bbt_pkg::LIST_DEPTH_DEF,
	parameter int HISTORY_DEPTH    = bbt_pkg::HISTORY_DEPTH_DEF,
	parameter int PENALTY_MULTIPLE = bbt_pkg::PENALTY_MULTIPLE_DEF,
	localparam int LIW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
	localparam int HIW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bbt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bbt_pkg::TIME_W-1:0]       cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bbt_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic [1:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bbt_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                             h_we,
	output logic [HIW-1:0]                   h_waddr,
	output logic [bbt_pkg::ENTRY_W-1:0]      h_wdata,
	output logic                             h_re,
	output logic [HIW-1:0]                   h_raddr,
	input  logic [bbt_pkg::ENTRY_W-1:0]      h_rdata,
	output logic                             l_we,
	output logic [LIW-1:0]                   l_waddr,
	output logic [bbt_pkg::ENTRY_W-1:0]      l_wdata,
	output logic                             l_re,
	output logic [LIW-1:0]                   l_raddr,
	input  logic [bbt_pkg::ENTRY_W-1:0]      l_rdata
);

	localparam int AW     = bbt_pkg::ADDR_W;
	localparam int TW     = bbt_pkg::TIME_W;
	localparam int SCAN_N = (LIST_DEPTH > HISTORY_DEPTH) ? LIST_DEPTH : HISTORY_DEPTH;
	localparam int CW     = $clog2(SCAN_N + 1);
	localparam int LCW    = $clog2(LIST_DEPTH + 1);
	localparam int RCW    = $clog2(SCAN_N + 1);
	localparam int PW     = TW + 5;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_MUL   = 6'b000100,
		ST_GRANT = 6'b001000,
		ST_WRITE = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;

	logic [TW-1:0] cap_q, period_q, overdue_q;
	bbt_pkg::mode_t mode_q;
	logic [AW-1:0] addr_q;
	logic [TW-1:0] svc_q, req_q, now_q;

	logic [CW-1:0] idx_q;
	logic          ev_vld_s1;
	logic [CW-1:0] ev_idx_s1;

	logic [HISTORY_DEPTH-1:0] hvalid_q;
	logic [LIST_DEPTH-1:0]    lvalid_q;
	logic [LCW-1:0]           list_cnt_q;
	logic [RCW-1:0]           removed_q;

	logic           hit_q, hfree_q, lfree_q, listed_q, penal_q;
	logic [HIW-1:0] hit_idx_q, hfree_idx_q;
	logic [LIW-1:0] lfree_idx_q;
	logic [TW-1:0]  old_q, prod_q, grant_q, granted_q;
	bbt_pkg::status_t status_q;

	logic                            m_tvalid_q;
	logic [bbt_pkg::OUT_DATA_W-1:0]  m_data_q;

	// Fields of the entries coming back from the memories.
	logic [AW-1:0] h_addr_rd, l_addr_rd;
	logic [TW-1:0] h_surv_rd, h_stamp_rd, l_surv_rd, l_stamp_rd;
	assign h_addr_rd  = h_rdata[2*TW +: AW];
	assign h_surv_rd  = h_rdata[TW +: TW];
	assign h_stamp_rd = h_rdata[0 +: TW];
	assign l_addr_rd  = l_rdata[2*TW +: AW];
	assign l_surv_rd  = l_rdata[TW +: TW];
	assign l_stamp_rd = l_rdata[0 +: TW];

	// Entry under evaluation in each table.
	logic           ev_h_ok, ev_l_ok, hv_ev, lv_ev;
	logic [HIW-1:0] hidx_ev;
	logic [LIW-1:0] lidx_ev;
	assign hidx_ev = ev_idx_s1[HIW-1:0];
	assign lidx_ev = ev_idx_s1[LIW-1:0];
	assign ev_h_ok = ev_vld_s1 && (ev_idx_s1 < CW'(HISTORY_DEPTH));
	assign ev_l_ok = ev_vld_s1 && (ev_idx_s1 < CW'(LIST_DEPTH));
	assign hv_ev   = ev_h_ok && hvalid_q[hidx_ev];
	assign lv_ev   = ev_l_ok && lvalid_q[lidx_ev];

	// Shared compare unit: one expiry test per cycle.
	logic run_out_ev;
	always_comb begin
		if (mode_q == bbt_pkg::MODE_WASH) begin
			run_out_ev = bbt_pkg::run_out(now_q, l_stamp_rd, l_surv_rd);
		end else begin
			run_out_ev = bbt_pkg::run_out(now_q, h_stamp_rd, overdue_q);
		end
	end

	// Scaled old survival at full width; ST_MUL saturates it to the time width.
	logic [PW-1:0] prod_full;
	assign prod_full = PW'(old_q) * PW'(PENALTY_MULTIPLE);

	// Penalty value limited by the cap.
	logic [TW-1:0] capped;
	assign capped = (prod_q > cap_q) ? cap_q : prod_q;

	// Read side of the scan.
	assign h_re    = (state_q == ST_SCAN) && (idx_q < CW'(HISTORY_DEPTH));
	assign h_raddr = idx_q[HIW-1:0];
	assign l_re    = (state_q == ST_SCAN) && (idx_q < CW'(LIST_DEPTH));
	assign l_raddr = idx_q[LIW-1:0];

	// Write side of an add.
	assign h_we    = (state_q == ST_WRITE) && (hit_q || hfree_q);
	assign h_waddr = hit_q ? hit_idx_q : hfree_idx_q;
	assign h_wdata = {addr_q, grant_q, now_q};
	assign l_we    = (state_q == ST_WRITE) && (hit_q || hfree_q) && lfree_q;
	assign l_waddr = lfree_idx_q;
	assign l_wdata = {addr_q, grant_q, now_q};

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= '0;
			period_q  <= '0;
			overdue_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				bbt_pkg::CFG_SURVIVAL_CAP:   cap_q     <= cfg_data;
				bbt_pkg::CFG_PENALTY_PERIOD: period_q  <= cfg_data;
				bbt_pkg::CFG_HIST_OVERDUE:   overdue_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Captured item fields.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_q <= bbt_pkg::mode_t'(s_tuser);
			addr_q <= s_tdata[0 +: AW];
			svc_q  <= s_tdata[AW +: TW];
			req_q  <= s_tdata[AW+TW +: TW];
			now_q  <= s_tdata[AW+2*TW +: TW];
		end
	end

	// Sequencer, scan results and table valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			ev_vld_s1   <= 1'b0;
			ev_idx_s1   <= '0;
			hvalid_q    <= '0;
			lvalid_q    <= '0;
			list_cnt_q  <= '0;
			removed_q   <= '0;
			hit_q       <= 1'b0;
			hfree_q     <= 1'b0;
			lfree_q     <= 1'b0;
			listed_q    <= 1'b0;
			penal_q     <= 1'b0;
			hit_idx_q   <= '0;
			hfree_idx_q <= '0;
			lfree_idx_q <= '0;
			old_q       <= '0;
			prod_q      <= '0;
			grant_q     <= '0;
			granted_q   <= '0;
			status_q    <= bbt_pkg::STAT_OK;
			m_tvalid_q  <= 1'b0;
			m_data_q    <= '0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						idx_q     <= '0;
						ev_vld_s1 <= 1'b0;
						removed_q <= '0;
						hit_q     <= 1'b0;
						hfree_q   <= 1'b0;
						lfree_q   <= 1'b0;
						listed_q  <= 1'b0;
						granted_q <= '0;
						status_q  <= bbt_pkg::STAT_OK;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// Issue the next address while the previous entry is judged.
					ev_vld_s1 <= (idx_q < CW'(SCAN_N));
					ev_idx_s1 <= idx_q;
					if (idx_q < CW'(SCAN_N)) begin
						idx_q <= idx_q + CW'(1);
					end
					case (mode_q)
						bbt_pkg::MODE_ADD: begin
							if (hv_ev && !hit_q && (h_addr_rd == addr_q)) begin
								hit_q     <= 1'b1;
								hit_idx_q <= hidx_ev;
								old_q     <= h_surv_rd;
							end
							if (ev_h_ok && !hvalid_q[hidx_ev] && !hfree_q) begin
								hfree_q     <= 1'b1;
								hfree_idx_q <= hidx_ev;
							end
							if (ev_l_ok && !lvalid_q[lidx_ev] && !lfree_q) begin
								lfree_q     <= 1'b1;
								lfree_idx_q <= lidx_ev;
							end
						end
						bbt_pkg::MODE_LOOKUP: begin
							if (lv_ev && (l_addr_rd == addr_q)) begin
								listed_q <= 1'b1;
							end
						end
						bbt_pkg::MODE_WASH: begin
							if (lv_ev && run_out_ev) begin
								lvalid_q[lidx_ev] <= 1'b0;
								list_cnt_q        <= list_cnt_q - LCW'(1);
								removed_q         <= removed_q + RCW'(1);
							end
						end
						bbt_pkg::MODE_CLEAR: begin
							if (hv_ev && run_out_ev) begin
								hvalid_q[hidx_ev] <= 1'b0;
								removed_q         <= removed_q + RCW'(1);
							end
						end
						default: ;
					endcase
					if ((idx_q == CW'(SCAN_N)) && !ev_vld_s1) begin
						state_q <= (mode_q == bbt_pkg::MODE_ADD) ? ST_MUL : ST_DONE;
					end
				end
				ST_MUL: begin
					prod_q  <= (|prod_full[PW-1:TW]) ? '1 : prod_full[TW-1:0];
					penal_q <= hit_q && (svc_q < period_q) && (old_q < cap_q);
					state_q <= ST_GRANT;
				end
				ST_GRANT: begin
					grant_q <= (penal_q && (capped > req_q)) ? capped : req_q;
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (!hit_q && !hfree_q) begin
						status_q <= bbt_pkg::STAT_HIST_FULL;
					end else begin
						if (!hit_q) begin
							hvalid_q[hfree_idx_q] <= 1'b1;
						end
						if (!lfree_q) begin
							status_q <= bbt_pkg::STAT_LIST_FULL;
						end else begin
							lvalid_q[lfree_idx_q] <= 1'b1;
							list_cnt_q            <= list_cnt_q + LCW'(1);
							granted_q             <= grant_q;
						end
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// Hand the result to the output register once it is free.
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_data_q   <= {2'b00, status_q, 6'(removed_q), 5'(list_cnt_q),
							listed_q, granted_q};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
